### sv/ptqd_pkg.sv
// Shared constants, types and codes for the priority task queue dispatcher.
package ptqd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int HANDLE_W    = 8;
    localparam int PRIO_W      = 8;
    localparam int OCC_W       = 5;
    localparam int CODE_W      = 2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // One queue slot as it is kept in the slot memory.
    typedef struct packed {
        logic                pending;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [CODE_W-1:0] {
        RC_INSERTED   = 2'd0,
        RC_FULL       = 2'd1,
        RC_DISPATCHED = 2'd2,
        RC_NONE       = 2'd3
    } result_code_t;

    localparam logic REQ_INSERT   = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    // Running outcome of the priority scan.
    typedef struct packed {
        logic                found;
        idx_t                best_idx;
        logic [HANDLE_W-1:0] best_handle;
        logic [PRIO_W-1:0]   best_prio;
    } scan_status_t;

endpackage

### sv/ptqd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ptqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/ptqd_scan.sv
// Compare unit that tracks the best pending entry over a serial scan.
module ptqd_scan import ptqd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         clear,
    input  logic         en,
    input  entry_t       entry,
    input  idx_t         idx,
    output scan_status_t status
);

    logic                found_reg;
    logic                found_next;
    idx_t                best_idx_reg;
    logic [HANDLE_W-1:0] best_handle_reg;
    logic [PRIO_W-1:0]   best_prio_reg;
    logic                take;

    // Strictly greater keeps the oldest entry among equal priorities.
    assign take = en && entry.pending && (!found_reg || (entry.prio > best_prio_reg));

    always_comb
    begin
        if (clear)
        begin
            found_next = 1'b0;
        end
        else
        begin
            found_next = found_reg | take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg    <= idx;
            best_handle_reg <= entry.handle;
            best_prio_reg   <= entry.prio;
        end
    end

    assign status.found       = found_reg;
    assign status.best_idx    = best_idx_reg;
    assign status.best_handle = best_handle_reg;
    assign status.best_prio   = best_prio_reg;

endmodule

### sv/priority_task_queue_dispatcher_core.sv
// Top level of the priority task queue dispatcher: sequencer, slot memory and scan unit.
//
//   Channel   Handshake             Beat contents
//   --------  --------------------  ----------------------------------------------------
//   request   start & !busy         req_type, task_handle, task_priority, eligible
//   result    result_valid (1 cyc)  result_code, out_handle, out_priority, occupancy
//
// An insert beat is answered in the cycle after it is accepted, whether it is stored or
// rejected because the queue is full; the block is ready again in that result cycle.
// A dispatch beat walks the slot memory one entry per cycle through its single read
// port, oldest entry first, and then decides; if the chosen entry is not the tail,
// each entry behind it is moved down one slot to close the gap (one read and one
// write per cycle) before the result is shown. An empty queue answers in the cycle
// after the request is accepted.
// Reset clears the entry count and the sequencer; the slot memory is not cleared,
// because only slots below the entry count are ever read.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module priority_task_queue_dispatcher_core import ptqd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                req_type,
    input  logic [HANDLE_W-1:0] task_handle,
    input  logic [PRIO_W-1:0]   task_priority,
    input  logic                eligible,
    output logic                result_valid,
    output logic [CODE_W-1:0]   result_code,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [PRIO_W-1:0]   out_priority,
    output logic [OCC_W-1:0]    occupancy
);

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_DECIDE = 5'b01000,
        S_SHIFT  = 5'b10000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    cnt_t                count_reg;
    cnt_t                count_next;
    cnt_t                ptr_reg;
    cnt_t                ptr_next;
    cnt_t                ptr_plus;
    cnt_t                best_plus;
    logic                chk_valid_reg;
    logic                chk_valid_next;
    idx_t                chk_idx_reg;
    idx_t                chk_idx_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    result_code_t        result_code_reg;
    result_code_t        result_code_next;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [HANDLE_W-1:0] out_handle_next;
    logic [PRIO_W-1:0]   out_priority_reg;
    logic [PRIO_W-1:0]   out_priority_next;

    logic                rd_en;
    idx_t                rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    entry_t              rd_entry;
    logic                wr_en;
    idx_t                wr_addr;
    entry_t              wr_entry;
    entry_t              new_entry;

    logic                scan_clear;
    logic                scan_en;
    scan_status_t        scan_status;

    assign rd_entry  = entry_t'(rd_data);
    assign ptr_plus  = ptr_reg + CNT_W'(1);
    assign best_plus = CNT_W'(scan_status.best_idx) + CNT_W'(1);

    assign new_entry.pending = eligible;
    assign new_entry.prio    = task_priority;
    assign new_entry.handle  = task_handle;

    // Read data returns in the cycle after its address, tagged by chk_valid_reg and
    // chk_idx_reg. During the scan it feeds the compare unit; during compaction it
    // is written back one slot lower.
    assign scan_en = chk_valid_reg && ((state_reg == S_SCAN) || (state_reg == S_DRAIN));

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ptr_next          = ptr_reg;
        chk_valid_next    = 1'b0;
        chk_idx_next      = chk_idx_reg;
        result_valid_next = 1'b0;
        result_code_next  = result_code_reg;
        out_handle_next   = out_handle_reg;
        out_priority_next = out_priority_reg;
        rd_en             = 1'b0;
        rd_addr           = ptr_reg[IDX_W-1:0];
        wr_en             = 1'b0;
        wr_addr           = count_reg[IDX_W-1:0];
        wr_entry          = new_entry;
        scan_clear        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_INSERT)
                    begin
                        result_valid_next = 1'b1;
                        out_handle_next   = '0;
                        out_priority_next = '0;
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            result_code_next = RC_FULL;
                        end
                        else
                        begin
                            // Append at the tail.
                            wr_en            = 1'b1;
                            count_next       = count_reg + CNT_W'(1);
                            result_code_next = RC_INSERTED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        result_valid_next = 1'b1;
                        result_code_next  = RC_NONE;
                        out_handle_next   = '0;
                        out_priority_next = '0;
                    end
                    else
                    begin
                        scan_clear = 1'b1;
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle, oldest entry first.
                rd_en          = 1'b1;
                chk_valid_next = 1'b1;
                chk_idx_next   = ptr_reg[IDX_W-1:0];
                ptr_next       = ptr_plus;
                if (ptr_plus == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                // The last entry is compared in this cycle.
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                if (!scan_status.found)
                begin
                    result_valid_next = 1'b1;
                    result_code_next  = RC_NONE;
                    out_handle_next   = '0;
                    out_priority_next = '0;
                    state_next        = S_IDLE;
                end
                else
                begin
                    result_code_next  = RC_DISPATCHED;
                    out_handle_next   = scan_status.best_handle;
                    out_priority_next = scan_status.best_prio;
                    if (best_plus == count_reg)
                    begin
                        // The chosen entry is the tail: nothing to move.
                        count_next        = count_reg - CNT_W'(1);
                        result_valid_next = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = best_plus;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                if (ptr_reg != count_reg)
                begin
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_plus;
                end
                if (chk_valid_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = chk_idx_reg - IDX_W'(1);
                    wr_entry = rd_entry;
                end
                if (ptr_reg == count_reg)
                begin
                    // The final move is written in this cycle.
                    count_next        = count_reg - CNT_W'(1);
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            ptr_reg          <= '0;
            chk_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ptr_reg          <= ptr_next;
            chk_valid_reg    <= chk_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg      <= chk_idx_next;
        result_code_reg  <= result_code_next;
        out_handle_reg   <= out_handle_next;
        out_priority_reg <= out_priority_next;
    end

    ptqd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ptqd_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (scan_clear),
        .en     (scan_en),
        .entry  (rd_entry),
        .idx    (chk_idx_reg),
        .status (scan_status)
    );

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result_code  = result_code_reg;
    assign out_handle   = out_handle_reg;
    assign out_priority = out_priority_reg;
    assign occupancy    = OCC_W'(count_reg);

`ifndef NO_ASSERTIONS
    // The entry count never passes the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // A result beat is only shown once the sequencer is back at rest.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    // An accepted insert is answered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_INSERT)) |=> result_valid)
        else $error("insert not answered in one cycle");

    // A dispatch removes exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_code == RC_DISPATCHED)) |->
            ((count_reg + CNT_W'(1)) == $past(count_reg)))
        else $error("dispatch did not remove one entry");

    // A stored insert adds exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_code == RC_INSERTED)) |->
            (count_reg == ($past(count_reg) + CNT_W'(1))))
        else $error("insert did not add one entry");
`endif

endmodule
